FILE: rtl/polynomial_evaluator_assert.svh
// Assertion macros used by the polynomial evaluator controller
`ifndef POLYNOMIAL_EVALUATOR_ASSERT_SVH
`define POLYNOMIAL_EVALUATOR_ASSERT_SVH

// check a property on every rising edge of i_clk outside reset
`define POLY_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that a condition never holds
`define POLY_NEVER(lbl, expr, msg) `POLY_ASSERT(lbl, !(expr), msg)

`endif

FILE: rtl/poly_pkg.sv
// Package of widths, register indexes and command types for the polynomial evaluator
package poly_pkg;

    localparam int MAX_DEGREE_DEF = 6;

    localparam int X_W       = 16;
    localparam int COEF_W    = 16;
    localparam int ACC_W     = 32;
    localparam int PROD_W    = ACC_W + X_W;
    localparam int FRAC_SH   = 12;
    localparam int COEF_SH   = 8;
    localparam int DEG_W     = 3;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 4'd1;

    typedef struct packed {
        logic             load;
        logic             mul;
        logic             add;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
    } t_dp_sts;

endpackage

FILE: rtl/poly_if.sv
// Handshake interfaces for the point, result and configuration channels
interface poly_in_if;
    import poly_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [X_W-1:0]   point;
    modport source (output valid, output point, input ready);
    modport sink   (input valid, input point, output ready);
endinterface

interface poly_out_if;
    import poly_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] value;
    logic                    overflow;
    modport source (output valid, output value, output overflow, input ready);
    modport sink   (input valid, input value, input overflow, output ready);
endinterface

interface poly_cfg_if;
    import poly_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/poly_ctrl.sv
// Controller sequencing the Horner steps of the polynomial evaluator
`include "polynomial_evaluator_assert.svh"

module poly_ctrl
    import poly_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = i_sts.degree;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_idx == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_MUL;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    `POLY_ASSERT(a_start_mul, (i_in_valid && o_in_ready) |=> (r_state == S_MUL), "accepted word did not start a step")
    `POLY_ASSERT(a_mul_add, (r_state == S_MUL) |=> (r_state == S_ADD), "multiply not followed by add")
    `POLY_ASSERT(a_rise_out, $rose(r_out_valid) |-> $past(r_state == S_OUT), "result shown without finishing")
    `POLY_NEVER(a_no_overwrite, o_cmd.out_load && r_out_valid && !i_out_ready, "waiting result overwritten")

endmodule

FILE: rtl/poly_dp.sv
// Datapath of the polynomial evaluator: registers, shared multiply-add and output register
module poly_dp
    import poly_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DAT_W-1:0]    i_cfg_data,
    input  logic signed [X_W-1:0]   i_point,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    output logic signed [ACC_W-1:0] o_value,
    output logic                    o_overflow
);

    localparam int NCOEF = MAX_DEGREE + 1;
    localparam int CW    = (NCOEF > 1) ? $clog2(NCOEF) : 1;
    localparam logic [CFG_IDX_W-1:0] LAST_REG = CFG_IDX_W'(MAX_DEGREE + 1);
    localparam logic [DEG_W-1:0]     DEG_MAX  = DEG_W'(MAX_DEGREE);
    localparam logic signed [PROD_W-1:0] P_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] P_MIN = PROD_W'(-64'sd2147483648);

    logic [DEG_W-1:0]         r_degree;
    logic signed [COEF_W-1:0] r_coef [NCOEF];
    logic signed [X_W-1:0]    r_x;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_ovf;
    logic signed [ACC_W-1:0]  r_value;
    logic                     r_ovf_out;

    logic [CFG_IDX_W-1:0]     cfg_slot;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [ACC_W-1:0]  acc_mul;
    logic                     ovf_mul;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  acc_add;
    logic                     ovf_add;

    assign cfg_slot     = i_cfg_index - REG_COEF0;
    assign o_sts.degree = (r_degree > DEG_MAX) ? DEG_MAX : r_degree;
    assign o_value      = r_value;
    assign o_overflow   = r_ovf_out;

    always_comb begin
        prod_sh = r_prod >>> FRAC_SH;
        ovf_mul = 1'b0;
        if (prod_sh > P_MAX) begin
            acc_mul = {1'b0, {(ACC_W-1){1'b1}}};
            ovf_mul = 1'b1;
        end else if (prod_sh < P_MIN) begin
            acc_mul = {1'b1, {(ACC_W-1){1'b0}}};
            ovf_mul = 1'b1;
        end else begin
            acc_mul = prod_sh[ACC_W-1:0];
        end
        sum     = (ACC_W+1)'(acc_mul) + ((ACC_W+1)'(r_coef[i_cmd.idx[CW-1:0]]) <<< COEF_SH);
        ovf_add = (sum[ACC_W] != sum[ACC_W-1]);
        if (ovf_add) begin
            acc_add = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_add = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            for (int k = 0; k < NCOEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_wr) begin
            if (i_cfg_index == REG_DEGREE) begin
                r_degree <= i_cfg_data[DEG_W-1:0];
            end else if (i_cfg_index <= LAST_REG) begin
                r_coef[cfg_slot[CW-1:0]] <= i_cfg_data[COEF_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_point;
            r_acc <= '0;
            r_ovf <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_acc) * PROD_W'(r_x);
        end
        if (i_cmd.add) begin
            r_acc <= acc_add;
            r_ovf <= r_ovf | ovf_mul | ovf_add;
        end
        if (i_cmd.out_load) begin
            r_value   <= r_acc;
            r_ovf_out <= r_ovf;
        end
    end

endmodule

FILE: rtl/polynomial_evaluator.sv
// Top level of the polynomial evaluator: controller, datapath and channel ports
// Usage:
//   i_cfg  : register writes, index 0 is the degree, 1 to MAX_DEGREE+1 the
//            Q8.8 coefficients of x^0 upwards; always ready, one word a cycle.
//            Write only while the block is idle; other indexes are ignored.
//   i_in   : one word per point, signed Q4.12; taken only when no point is
//            in evaluation.
//   o_out  : one word per point, signed Q16.16 value, saturated, with an
//            overflow flag for any step that clamped.
// Timing: an accepted point runs one Horner step per coefficient from x^d
//   down to x^0, d being the degree clipped to MAX_DEGREE, and is then loaded
//   into the output register from S_OUT; each step uses the shared multiplier
//   in S_MUL and the shift, saturate and add in S_ADD. The next point is taken
//   in the cycle after the result is loaded, so a point is taken only once the
//   one before it is through.
// Stall: the result waits in the output register; the next point is accepted
//   and evaluated meanwhile, and holds before loading until the word is taken.
// Reset: degree and coefficients return to zero and no result is pending.
module polynomial_evaluator
    import poly_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    poly_in_if.sink    i_in,
    poly_out_if.source o_out,
    poly_cfg_if.sink   i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    poly_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    poly_dp #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_point     (i_in.point),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_value     (o_out.value),
        .o_overflow  (o_out.overflow)
    );

endmodule

FILE: tb/polynomial_evaluator_test.sv
// Self-checking testbench of the polynomial evaluator: fixed-point Horner predictor, directed tests and random traffic
`timescale 1ns / 100ps

module polynomial_evaluator_test;
    import poly_pkg::*;

    localparam int    CLK_PERIOD  = 8;
    localparam int    RESET_CYCLES = 11;
    localparam int    CYCLE_LIMIT = 600000;
    localparam int    DRAIN_CYCLES = 2 * (MAX_DEGREE_DEF + 1) + 8;
    localparam int    ITEM_TARGET = 1950;
    localparam int    STEADY_TAIL = 200;
    localparam longint ACC_HIGH   = 64'sd2147483647;
    localparam longint ACC_LOW    = -64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = CFG_IDX_W'(REG_COEF0 + MAX_DEGREE_DEF);

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    overflow;
    } t_poly_result;

    logic i_clk;
    logic i_rst_n;

    poly_in_if  in_bus();
    poly_out_if out_bus();
    poly_cfg_if cfg_bus();

    polynomial_evaluator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    logic [DEG_W-1:0]         degree_shadow;
    logic signed [COEF_W-1:0] coef_shadow [MAX_DEGREE_DEF+1];
    t_poly_result             pending_values [$];
    t_poly_result             head_result;
    int                       mismatches;
    int                       cycle_count;
    int                       points_sent;
    bit                       idling;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic t_poly_result eval_horner(input logic signed [X_W-1:0] x);
        longint       acc;
        int           top;
        int           i;
        t_poly_result r;
        top = (int'(degree_shadow) > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : int'(degree_shadow);
        acc = 0;
        r.overflow = 1'b0;
        for (i = top; i >= 0; i--) begin
            acc = (acc * longint'(x)) >>> FRAC_SH;
            if (acc > ACC_HIGH) begin
                acc = ACC_HIGH;
                r.overflow = 1'b1;
            end else if (acc < ACC_LOW) begin
                acc = ACC_LOW;
                r.overflow = 1'b1;
            end
            acc = acc + (longint'(coef_shadow[i]) <<< COEF_SH);
            if (acc > ACC_HIGH) begin
                acc = ACC_HIGH;
                r.overflow = 1'b1;
            end else if (acc < ACC_LOW) begin
                acc = ACC_LOW;
                r.overflow = 1'b1;
            end
        end
        r.value = acc[ACC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (idx == REG_DEGREE) begin
            degree_shadow = data[DEG_W-1:0];
        end else if (idx >= REG_COEF0 && idx <= REG_COEF_TOP) begin
            coef_shadow[IDX_W'(idx - REG_COEF0)] = data;
        end
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_point(input logic signed [X_W-1:0] x);
        int gap;
        @(negedge i_clk);
        in_bus.valid <= 1'b1;
        in_bus.point <= x;
        do @(posedge i_clk); while (!in_bus.ready);
        pending_values.push_back(eval_horner(x));
        points_sent++;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_coefs(input logic [CFG_DAT_W-1:0] value);
        int i;
        for (i = 0; i <= MAX_DEGREE_DEF; i++) begin
            write_reg(CFG_IDX_W'(REG_COEF0 + i), value);
        end
    endtask

    task automatic test_reset_state();
        send_point(16'sh7FFF);
        send_point(-16'sh8000);
        send_point(16'sh1000);
        settle();
    endtask

    task automatic test_saturation();
        write_reg(REG_DEGREE, 16'd6);
        load_coefs(16'h7FFF);
        send_point(16'sh7FFF);
        send_point(-16'sh8000);
        send_point(16'sh0000);
        settle();
        load_coefs(16'h8000);
        send_point(16'sh7FFF);
        send_point(-16'sh8000);
        send_point(-16'sh0001);
        settle();
    endtask

    task automatic test_degree_clip();
        int i;
        write_reg(REG_DEGREE, 16'hFFFF);
        for (i = 0; i <= MAX_DEGREE_DEF; i++) begin
            write_reg(CFG_IDX_W'(REG_COEF0 + i), (i % 2) ? 16'h0100 : 16'hFF00);
        end
        send_point(16'sh1000);
        send_point(-16'sh1000);
        settle();
        write_reg(REG_DEGREE, 16'hFFF8);
        write_reg(REG_COEF0, 16'h7FFF);
        send_point(16'sh0001);
        settle();
        write_reg(REG_COEF0, 16'h8000);
        send_point(16'sh0001);
        settle();
    endtask

    task automatic test_index_range();
        logic [CFG_IDX_W-1:0] idx;
        write_reg(REG_DEGREE, 16'd2);
        load_coefs(16'h0080);
        for (idx = REG_COEF_TOP + 1'b1; idx != 0; idx++) begin
            write_reg(idx, 16'($urandom));
        end
        send_point(16'sh0800);
        send_point(-16'sh4000);
        settle();
    endtask

    task automatic test_random_traffic();
        int phase;
        int count;
        int i;
        int mode;
        logic [CFG_DAT_W-1:0]     coef;
        logic signed [X_W-1:0]    x;
        phase = 0;
        while (points_sent < ITEM_TARGET) begin
            write_reg(REG_DEGREE,
                      {13'($urandom), (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7))});
            mode = $urandom_range(0, 3);
            for (i = 0; i <= MAX_DEGREE_DEF; i++) begin
                case (mode)
                    0: coef = 16'($urandom);
                    1: begin
                        case ($urandom_range(0, 3))
                            0: coef = 16'h7FFF;
                            1: coef = 16'h8000;
                            2: coef = 16'h0000;
                            default: coef = 16'($urandom);
                        endcase
                    end
                    default: coef = 16'($signed($urandom_range(0, 1023)) - 512);
                endcase
                write_reg(CFG_IDX_W'(REG_COEF0 + i), coef);
            end
            count = $urandom_range(60, 140);
            if (count > ITEM_TARGET - points_sent) begin
                count = ITEM_TARGET - points_sent;
            end
            repeat (count) begin
                idling = (points_sent < ITEM_TARGET - STEADY_TAIL);
                case ($urandom_range(0, 9))
                    0, 1: x = 16'($urandom);
                    2: x = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
                    default: x = 16'($signed($urandom_range(0, 8192)) - 4096);
                endcase
                send_point(x);
            end
            settle();
            phase++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_bus.valid  = 1'b0;
        in_bus.point  = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data  = '0;
        degree_shadow = '0;
        for (int i = 0; i <= MAX_DEGREE_DEF; i++) coef_shadow[i] = '0;
        mismatches  = 0;
        points_sent = 0;
        idling      = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_saturation();
        test_degree_clip();
        test_index_range();
        test_random_traffic();
        settle();

        if (mismatches == 0) begin
            $display("polynomial_evaluator regression: pass");
        end else begin
            $display("polynomial_evaluator regression: fail");
        end
        $finish;
    end

    initial begin
        int run;
        int stall;
        out_bus.ready = 1'b0;
        forever begin
            run = $urandom_range(1, 24);
            repeat (run) begin
                @(negedge i_clk);
                out_bus.ready <= 1'b1;
            end
            if (idling) begin
                stall = $urandom_range(1, 14);
                repeat (stall) begin
                    @(negedge i_clk);
                    out_bus.ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_values.size() == 0) begin
                report_mismatch($sformatf("word with nothing pending, value %h", out_bus.value));
            end else begin
                head_result = pending_values.pop_front();
                if (out_bus.value !== head_result.value) begin
                    report_mismatch($sformatf("value %h, predicted %h",
                                              out_bus.value, head_result.value));
                end
                if (out_bus.overflow !== head_result.overflow) begin
                    report_mismatch($sformatf("overflow %b, predicted %b",
                                              out_bus.overflow, head_result.overflow));
                end
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("polynomial_evaluator regression: fail");
            $finish;
        end
    end

endmodule
